/* hdl/json_pretty_printer_assert.svh */
// Assertion macros shared by the pretty printer modules.
`ifndef JSON_PRETTY_PRINTER_ASSERT_SVH
`define JSON_PRETTY_PRINTER_ASSERT_SVH

// Check cons in the same cycle as ante.
`define JPP_AST_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("json_pretty_printer: same-cycle check failed");

// Check cons in the cycle after ante.
`define JPP_AST_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("json_pretty_printer: next-cycle check failed");

`endif

/* hdl/jpp_pkg.sv */
// Types and constants shared by the pretty printer modules.
`default_nettype none

package jpp_pkg;

    localparam int LVL_W = 5;
    localparam int CNT_W = LVL_W + 1;

    localparam logic [7:0] CH_NL     = 8'h0A;
    localparam logic [7:0] CH_SP     = 8'h20;
    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_COMMA  = 8'h2C;
    localparam logic [7:0] CH_COLON  = 8'h3A;
    localparam logic [7:0] CH_LBRACK = 8'h5B;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_RBRACK = 8'h5D;
    localparam logic [7:0] CH_LBRACE = 8'h7B;
    localparam logic [7:0] CH_RBRACE = 8'h7D;

    typedef enum logic [2:0] {
        KIND_PLAIN,
        KIND_COMMA,
        KIND_COLON,
        KIND_OPEN,
        KIND_CLOSE
    } kind_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_HEAD,
        ST_NL,
        ST_SP,
        ST_TAIL
    } state_t;

    typedef enum logic [1:0] {
        SEL_BYTE,
        SEL_NL,
        SEL_SP
    } sel_t;

    typedef struct packed {
        logic take;
        logic emit;
        sel_t sel;
        logic last;
        logic load_cnt;
        logic dec_cnt;
    } cmd_t;

    typedef struct packed {
        kind_t kind_in;
        kind_t kind;
        logic  lvl_zero;
        logic  cnt_zero;
        logic  cnt_one;
        logic  out_free;
    } sts_t;

endpackage

`default_nettype wire

/* hdl/jpp_ctrl.sv */
// Sequencer that steps through the output bytes of one input byte.
`default_nettype none

module jpp_ctrl
    import jpp_pkg::*;
(
    input  wire logic aclk,
    input  wire logic aresetn,
    input  wire logic s_tvalid,
    input  wire sts_t sts,
    output cmd_t      cmd
);

`include "json_pretty_printer_assert.svh"

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    state_next = (sts.kind_in == KIND_CLOSE) ? ST_NL : ST_HEAD;
                end
            end
            ST_HEAD: begin
                if (sts.out_free) begin
                    priority if (sts.kind == KIND_PLAIN) begin
                        state_next = ST_IDLE;
                    end else if (sts.kind == KIND_COLON) begin
                        state_next = ST_TAIL;
                    end else begin
                        state_next = ST_NL;
                    end
                end
            end
            ST_NL: begin
                if (sts.out_free) begin
                    priority if (!sts.lvl_zero) begin
                        state_next = ST_SP;
                    end else if (sts.kind == KIND_CLOSE) begin
                        state_next = ST_TAIL;
                    end else begin
                        state_next = ST_IDLE;
                    end
                end
            end
            ST_SP: begin
                if (sts.out_free && sts.cnt_one) begin
                    state_next = (sts.kind == KIND_CLOSE) ? ST_TAIL : ST_IDLE;
                end
            end
            ST_TAIL: begin
                if (sts.out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        cmd = '0;
        cmd.sel = SEL_BYTE;
        unique case (state_reg)
            ST_IDLE: begin
                cmd.take = 1'b1;
            end
            ST_HEAD: begin
                cmd.emit = sts.out_free;
                cmd.sel  = SEL_BYTE;
                cmd.last = (sts.kind == KIND_PLAIN);
            end
            ST_NL: begin
                cmd.emit     = sts.out_free;
                cmd.sel      = SEL_NL;
                cmd.last     = sts.lvl_zero && (sts.kind != KIND_CLOSE);
                cmd.load_cnt = sts.out_free;
            end
            ST_SP: begin
                cmd.emit    = sts.out_free;
                cmd.sel     = SEL_SP;
                cmd.last    = sts.cnt_one && (sts.kind != KIND_CLOSE);
                cmd.dec_cnt = sts.out_free;
            end
            ST_TAIL: begin
                cmd.emit = sts.out_free;
                cmd.sel  = (sts.kind == KIND_COLON) ? SEL_SP : SEL_BYTE;
                cmd.last = 1'b1;
            end
            default: begin
                cmd.take = 1'b0;
            end
        endcase
    end

    `JPP_AST_IMP(a_emit_free, cmd.emit, sts.out_free)
    `JPP_AST_IMP(a_sp_count, state_reg == ST_SP, !sts.cnt_zero)

endmodule

`default_nettype wire

/* hdl/jpp_dp.sv */
// Parser state, space counter and output register of the pretty printer.
`default_nettype none

module jpp_dp
    import jpp_pkg::*;
#(
    parameter int MAX_NEST = 31
) (
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       s_tvalid,
    input  wire logic [7:0] s_tdata,
    output logic            m_tvalid,
    input  wire logic       m_tready,
    output logic [7:0]      m_tdata,
    output logic            m_tlast,
    input  wire cmd_t       cmd,
    output sts_t            sts
);

`include "json_pretty_printer_assert.svh"

    localparam logic [LVL_W-1:0] LVL_MAX = LVL_W'(MAX_NEST);

    logic             accept;
    kind_t            kind_in;
    logic [7:0]       byte_reg;
    kind_t            kind_reg;
    logic [LVL_W-1:0] lvl_reg;
    logic [LVL_W-1:0] lvl_next;
    logic             quoted_reg;
    logic             quoted_next;
    logic             bs_reg;
    logic             bs_next;
    logic [CNT_W-1:0] cnt_reg;
    logic [7:0]       out_data_reg;
    logic [7:0]       out_data_next;
    logic             out_last_reg;
    logic             out_valid_reg;

    assign accept = s_tvalid && cmd.take;

    always_comb begin
        kind_in = KIND_PLAIN;
        if (!quoted_reg) begin
            unique case (s_tdata)
                CH_COMMA:            kind_in = KIND_COMMA;
                CH_COLON:            kind_in = KIND_COLON;
                CH_LBRACE, CH_LBRACK: kind_in = KIND_OPEN;
                CH_RBRACE, CH_RBRACK: kind_in = KIND_CLOSE;
                default:             kind_in = KIND_PLAIN;
            endcase
        end
    end

    always_comb begin
        lvl_next    = lvl_reg;
        quoted_next = quoted_reg;
        bs_next     = bs_reg;
        if (quoted_reg) begin
            priority if (bs_reg) begin
                bs_next = 1'b0;
            end else if (s_tdata == CH_BSLASH) begin
                bs_next = 1'b1;
            end else if (s_tdata == CH_QUOTE) begin
                quoted_next = 1'b0;
            end
        end else begin
            bs_next = 1'b0;
            if (s_tdata == CH_QUOTE) begin
                quoted_next = 1'b1;
            end
            if (kind_in == KIND_OPEN && lvl_reg < LVL_MAX) begin
                lvl_next = lvl_reg + 1'b1;
            end
            if (kind_in == KIND_CLOSE && lvl_reg != '0) begin
                lvl_next = lvl_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            lvl_reg    <= '0;
            quoted_reg <= 1'b0;
            bs_reg     <= 1'b0;
        end else if (accept) begin
            lvl_reg    <= lvl_next;
            quoted_reg <= quoted_next;
            bs_reg     <= bs_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            byte_reg <= s_tdata;
            kind_reg <= kind_in;
        end
        if (cmd.load_cnt) begin
            cnt_reg <= {lvl_reg, 1'b0};
        end else if (cmd.dec_cnt) begin
            cnt_reg <= cnt_reg - 1'b1;
        end
    end

    always_comb begin
        unique case (cmd.sel)
            SEL_BYTE: out_data_next = byte_reg;
            SEL_NL:   out_data_next = CH_NL;
            SEL_SP:   out_data_next = CH_SP;
            default:  out_data_next = byte_reg;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (cmd.emit) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.emit) begin
            out_data_reg <= out_data_next;
            out_last_reg <= cmd.last;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tlast  = out_last_reg;

    assign sts.kind_in  = kind_in;
    assign sts.kind     = kind_reg;
    assign sts.lvl_zero = (lvl_reg == '0);
    assign sts.cnt_zero = (cnt_reg == '0);
    assign sts.cnt_one  = (cnt_reg == CNT_W'(1));
    assign sts.out_free = !out_valid_reg || m_tready;

    `JPP_AST_IMP(a_lvl_max, 1'b1, lvl_reg <= LVL_MAX)
    `JPP_AST_IMP(a_bs_in_str, bs_reg, quoted_reg)
    `JPP_AST_NXT(a_lvl_hold, !accept, $stable(lvl_reg))

endmodule

`default_nettype wire

/* hdl/json_pretty_printer.sv */
// Path: an accepted input word is registered, then its first output word is loaded
// into the output register. Throughput: the single-entry output register and
// sequencer give one output word per cycle while m_tready is high; a run is 1 or 2
// words, or 2 + 2*depth for a comma or bracket; the next input waits for the run.
// Reset: synchronous active-low aresetn clears depth, string and escape flags.
`default_nettype none

module json_pretty_printer
    import jpp_pkg::*;
#(
    parameter int MAX_NEST = 31
) (
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       s_tvalid,
    output logic            s_tready,
    input  wire logic [7:0] s_tdata,   // [7:0] in_byte
    output logic            m_tvalid,
    input  wire logic       m_tready,
    output logic [7:0]      m_tdata,   // [7:0] out_byte
    output logic            m_tlast
);

    cmd_t cmd;
    sts_t sts;

    jpp_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .sts      (sts),
        .cmd      (cmd)
    );

    jpp_dp #(
        .MAX_NEST (MAX_NEST)
    ) u_dp (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .cmd      (cmd),
        .sts      (sts)
    );

    assign s_tready = cmd.take;

endmodule

`default_nettype wire

/* dv/testbench.sv */
// Self-checking stream testbench for the JSON pretty printer: directed, deep nesting, random.
module testbench;
    import jpp_pkg::*;

    localparam int NEST_MAX      = 31;
    localparam int CYCLE_LIMIT   = 1_000_000;
    localparam int RANDOM_WORDS  = 75;
    localparam int N_DIRECTED    = 24;
    localparam int DRAIN_CYCLES  = 20;

    typedef struct packed {
        logic [7:0] data;
        logic       last;
    } text_word_t;

    // w0 is the first typed output word; n_typed == 0 leaves the row to the formatter
    typedef struct packed {
        logic [7:0] in_byte;
        logic [1:0] n_typed;
        logic [7:0] w0;
        logic [7:0] w1;
    } dir_row_t;

    logic       aclk = 1'b0;
    logic       aresetn;
    logic       s_tvalid;
    logic       s_tready;
    logic [7:0] s_tdata;    // [7:0] in_byte
    logic       m_tvalid;
    logic       m_tready = 1'b0;
    logic [7:0] m_tdata;    // [7:0] out_byte
    logic       m_tlast;

    json_pretty_printer #(.MAX_NEST(NEST_MAX)) dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    // formatter state
    logic [4:0] depth_lvl;
    logic       in_string;
    logic       escape_armed;

    text_word_t expected_text[$];
    text_word_t run_words[$];
    text_word_t head_word;

    int s_idle_pct = 25;
    int m_idle_pct = 85;
    int mismatch_count = 0;
    int words_sent = 0;
    int words_seen = 0;
    int deepest = 0;
    int cycle_count = 0;

    dir_row_t directed_rows [N_DIRECTED] = '{
        '{CH_RBRACE, 2'd2, CH_NL,     CH_RBRACE},
        '{CH_RBRACK, 2'd2, CH_NL,     CH_RBRACK},
        '{8'h00,     2'd1, 8'h00,     8'h00},
        '{8'hFF,     2'd1, 8'hFF,     8'h00},
        '{8'h41,     2'd1, 8'h41,     8'h00},
        '{CH_COLON,  2'd2, CH_COLON,  CH_SP},
        '{CH_COMMA,  2'd2, CH_COMMA,  CH_NL},
        '{CH_LBRACE, 2'd0, 8'h00,     8'h00},
        '{CH_QUOTE,  2'd1, CH_QUOTE,  8'h00},
        '{CH_COMMA,  2'd1, CH_COMMA,  8'h00},
        '{CH_LBRACE, 2'd1, CH_LBRACE, 8'h00},
        '{CH_BSLASH, 2'd1, CH_BSLASH, 8'h00},
        '{CH_QUOTE,  2'd1, CH_QUOTE,  8'h00},
        '{CH_BSLASH, 2'd1, CH_BSLASH, 8'h00},
        '{CH_BSLASH, 2'd1, CH_BSLASH, 8'h00},
        '{CH_QUOTE,  2'd1, CH_QUOTE,  8'h00},
        '{CH_COLON,  2'd2, CH_COLON,  CH_SP},
        '{CH_LBRACK, 2'd0, 8'h00,     8'h00},
        '{8'h31,     2'd1, 8'h31,     8'h00},
        '{CH_COMMA,  2'd0, 8'h00,     8'h00},
        '{8'h7F,     2'd1, 8'h7F,     8'h00},
        '{CH_RBRACK, 2'd0, 8'h00,     8'h00},
        '{CH_RBRACE, 2'd0, 8'h00,     8'h00},
        '{CH_NL,     2'd1, CH_NL,     8'h00}
    };

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end
    end

    always @(negedge aclk) begin
        m_tready <= ($urandom_range(99) >= m_idle_pct);
    end

    task automatic report_mismatch(input string what, input logic [7:0] got,
                                   input logic [7:0] want);
        mismatch_count++;
        $display("ERROR: %s at output word %0d: got %h, want %h", what, words_seen, got, want);
    endtask

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            words_seen++;
            if (expected_text.size() == 0) begin
                report_mismatch("unexpected word", m_tdata, 8'h00);
            end else begin
                head_word = expected_text.pop_front();
                if (m_tdata !== head_word.data)
                    report_mismatch("out_byte", m_tdata, head_word.data);
                if (m_tlast !== head_word.last)
                    report_mismatch("run_end", {7'b0, m_tlast}, {7'b0, head_word.last});
            end
        end
    end

    function automatic void add_word(input logic [7:0] b);
        text_word_t w;
        w.data = b;
        w.last = 1'b0;
        run_words = {run_words, w};
    endfunction

    function automatic void add_break();
        int i;
        add_word(CH_NL);
        for (i = 0; i < depth_lvl; i++) begin
            add_word(CH_SP);
            add_word(CH_SP);
        end
    endfunction

    // compute the formatted run for one input byte and advance the state
    function automatic void format_byte(input logic [7:0] c);
        run_words.delete();
        if (in_string) begin
            add_word(c);
            if (escape_armed)
                escape_armed = 1'b0;
            else if (c == CH_BSLASH)
                escape_armed = 1'b1;
            else if (c == CH_QUOTE)
                in_string = 1'b0;
        end else begin
            escape_armed = 1'b0;
            case (c)
                CH_COMMA: begin
                    add_word(c);
                    add_break();
                end
                CH_COLON: begin
                    add_word(c);
                    add_word(CH_SP);
                end
                CH_LBRACE, CH_LBRACK: begin
                    add_word(c);
                    if (depth_lvl < NEST_MAX)
                        depth_lvl = depth_lvl + 1'b1;
                    add_break();
                end
                CH_RBRACE, CH_RBRACK: begin
                    if (depth_lvl > 0)
                        depth_lvl = depth_lvl - 1'b1;
                    add_break();
                    add_word(c);
                end
                CH_QUOTE: begin
                    in_string = 1'b1;
                    add_word(c);
                end
                default: add_word(c);
            endcase
        end
        run_words[run_words.size() - 1].last = 1'b1;
    endfunction

    function automatic logic [7:0] pick_byte();
        int r;
        r = $urandom_range(99);
        if (in_string) begin
            if (r < 10) return CH_BSLASH;
            if (r < 25) return CH_QUOTE;
            if (r < 80) return 8'($urandom_range(8'h7E, 8'h20));
            return 8'($urandom_range(255));
        end
        if (r < 8) return 8'($urandom_range(255));
        if (r < 22) begin
            if (depth_lvl > 6) return $urandom_range(1) ? CH_RBRACE : CH_RBRACK;
            return $urandom_range(1) ? CH_LBRACE : CH_LBRACK;
        end
        if (r < 36) return $urandom_range(1) ? CH_RBRACE : CH_RBRACK;
        if (r < 50) return CH_COMMA;
        if (r < 60) return CH_COLON;
        if (r < 76) return CH_QUOTE;
        if (r < 88) return 8'($urandom_range(8'h39, 8'h30));
        return 8'($urandom_range(8'h7A, 8'h61));
    endfunction

    // call at a falling edge; returns at the falling edge after the handshake
    task automatic send_word(input logic [7:0] b, input logic [1:0] n_typed = 2'd0,
                             input logic [7:0] w0 = 8'h00, input logic [7:0] w1 = 8'h00);
        text_word_t w;
        while ($urandom_range(99) < s_idle_pct) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        @(negedge aclk);
        words_sent++;
        format_byte(b);
        if (depth_lvl > deepest)
            deepest = depth_lvl;
        if (n_typed == 2'd0) begin
            expected_text = {expected_text, run_words};
        end else begin
            w.data = w0;
            w.last = (n_typed == 2'd1);
            expected_text = {expected_text, w};
            if (n_typed == 2'd2) begin
                w.data = w1;
                w.last = 1'b1;
                expected_text = {expected_text, w};
            end
        end
    endtask

    // hold the sender until every pending output word has arrived
    task automatic drain_words();
        s_tvalid <= 1'b0;
        while (expected_text.size() != 0) @(negedge aclk);
    endtask

    initial begin
        int p;
        int i;
        aresetn      = 1'b0;
        s_tvalid     = 1'b0;
        s_tdata      = 8'h00;
        depth_lvl    = '0;
        in_string    = 1'b0;
        escape_armed = 1'b0;
        repeat (4) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        for (i = 0; i < N_DIRECTED; i++)
            send_word(directed_rows[i].in_byte, directed_rows[i].n_typed,
                      directed_rows[i].w0, directed_rows[i].w1);

        // drive the depth past its ceiling and back below zero
        for (i = 0; i < NEST_MAX + 2; i++)
            send_word($urandom_range(1) ? CH_LBRACE : CH_LBRACK);
        send_word(CH_COMMA);
        send_word(CH_COLON);
        for (i = 0; i < NEST_MAX + 3; i++)
            send_word($urandom_range(1) ? CH_RBRACE : CH_RBRACK);
        drain_words();

        for (p = 0; p < 3; p++) begin
            case (p)
                0: begin s_idle_pct = 25; m_idle_pct = 85; end
                1: begin s_idle_pct = 85; m_idle_pct = 25; end
                default: begin s_idle_pct = 0; m_idle_pct = 0; end
            endcase
            for (i = 0; i < RANDOM_WORDS; i++)
                send_word(pick_byte());
            drain_words();
        end

        repeat (DRAIN_CYCLES) @(posedge aclk);
        $display("Run covered %0d input words and %0d output words, deepest nesting %0d.",
                 words_sent, words_seen, deepest);
        $display("Directed table, nesting saturation at both ends, three idle/stall mixes.");
        if (mismatch_count == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end
endmodule
